// ===== src/note_duration_tracker_core_defines.svh =====
// Assertion macros for the note duration tracker.
`ifndef NOTE_DURATION_TRACKER_CORE_DEFINES_SVH
`define NOTE_DURATION_TRACKER_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define NDT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define NDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ndt_pkg.sv =====
// Shared types and constants of the note duration tracker.
`timescale 1ns / 1ps
`default_nettype none

package ndt_pkg;

   localparam int ACTIVE_SLOTS_DEFAULT = 64;
   localparam int KEY_COUNT            = 128;
   localparam int KEY_W                = 7;
   localparam int TIME_W               = 32;
   localparam int LEN_W                = 31;
   localparam int TRACK_W              = 3;
   localparam int VEL_W                = 7;
   localparam int REQ_DATA_W           = 112;
   localparam int RSP_DATA_W           = 16;
   localparam int CSR_DATA_W           = 8;

   localparam logic [VEL_W-1:0] VEL_ON  = 7'd60;
   localparam logic [VEL_W-1:0] VEL_OFF = 7'd0;

   // Item kinds on the request side
   localparam logic REQ_NOTE = 1'b0;
   localparam logic REQ_TIME = 1'b1;

   // Event kinds on the response side
   localparam logic EVT_ON  = 1'b0;
   localparam logic EVT_OFF = 1'b1;

   // Register indexes
   localparam logic REG_TRACK_MASK = 1'b0;
   localparam logic REG_EVENT_EN   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFER,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

// ===== src/note_duration_tracker_core.sv =====
// Top level of the note duration tracker: slot memory and scan sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to ACTIVE_SLOTS sounding notes in a slot memory (key and end
// time) with a 128-bit sounding map in flip-flops. A note offer is
// accepted in the idle state and then checked and appended in the offer
// state, emitting a note-on; a result still waiting in the output register
// holds the offer state. A time item scans the slots from index 0 through
// a read/evaluate loop around the memory's registered read. Each slot held
// when the item arrives costs one visit, a read and an evaluate, since a
// removal revisits its index in place of moving on. A scan thus runs
// through the accept, the visits, the closing read and a flush that hands
// the final note-off over; the result side holding off a waiting note-off stalls it.
// Removals swap the last slot into the freed one,
// which is then examined again. The last result of an item carries tlast.
// Requests are taken only between items; a waiting result does not hold
// off a new request. No clearing pass follows reset.
module note_duration_tracker_core #(
   parameter int ACTIVE_SLOTS = ndt_pkg::ACTIVE_SLOTS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   // Configuration write port
   input  wire                              csr_we,
   input  wire                              csr_addr,
   input  wire  [ndt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // Request channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // tdata: note_key[6:0], track_id[9:7], start_time[41:10],
   //        note_length[72:42], new_time[104:73], zero fill
   input  wire  [ndt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: req_type
   input  wire                              req_tuser,
   // Response channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata: event_key[6:0], velocity[13:7], zero fill
   output logic [ndt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: event_kind
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import ndt_pkg::*;

`include "note_duration_tracker_core_defines.svh"

   localparam int CNT_W  = $clog2(ACTIVE_SLOTS + 1);
   localparam int IDX_W  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int SLOT_W = KEY_W + TIME_W;

   // Configuration
   logic [7:0]             track_mask_ff;
   logic                   event_en_ff;

   // Control state
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [KEY_COUNT-1:0]   sounding_ff, sounding_in;
   logic signed [TIME_W-1:0] now_ff, now_in;

   // Latched offer
   logic [KEY_W-1:0]       off_key_ff;
   logic [TRACK_W-1:0]     off_track_ff;
   logic signed [TIME_W-1:0] off_start_ff;
   logic [LEN_W-1:0]       off_len_ff;

   // Pending note-off, held until its successor or the end of the scan
   logic                   pend_valid_ff, pend_valid_in;
   logic [KEY_W-1:0]       pend_key_ff, pend_key_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Slot memory
   logic [SLOT_W-1:0]      slot_mem [ACTIVE_SLOTS];
   logic [SLOT_W-1:0]      rd_cur_ff, rd_last_ff;
   logic [IDX_W-1:0]       rd_last_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [SLOT_W-1:0]      wr_data;

   logic                   req_take;
   logic                   out_free;
   logic                   push;
   logic                   push_kind;
   logic [KEY_W-1:0]       push_key;
   logic                   push_last;

   logic signed [TIME_W:0] end_sum;
   logic signed [TIME_W-1:0] end_sat;
   logic                   offer_ok;
   logic                   expired;
   logic [CNT_W-1:0]       count_dec;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_dec  = count_ff - 1'b1;
   assign rd_last_addr = count_dec[IDX_W-1:0];

   // Saturating end time and the acceptance test of an offer
   assign end_sum = {off_start_ff[TIME_W-1], off_start_ff}
                  + $signed({2'b00, off_len_ff});
   assign end_sat = (end_sum[TIME_W:TIME_W-1] == 2'b01)
                  ? $signed({1'b0, {(TIME_W-1){1'b1}}})
                  : end_sum[TIME_W-1:0];
   assign offer_ok = track_mask_ff[off_track_ff] && !sounding_ff[off_key_ff]
                  && (off_start_ff < now_ff) && (now_ff < end_sat)
                  && (count_ff < CNT_W'(ACTIVE_SLOTS));

   assign expired = $signed(rd_cur_ff[TIME_W-1:0]) < now_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_tuser == REQ_TIME) ? ST_READ : ST_OFFER;
            end
         end
         ST_OFFER: begin
            if (!(offer_ok && event_en_ff && !out_free)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = (idx_ff < count_ff) ? ST_EVAL : ST_FLUSH;
         end
         ST_EVAL: begin
            if (!(expired && event_en_ff && pend_valid_ff && !out_free)) begin
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and result generation
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      sounding_in   = sounding_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = rd_last_ff;
      push          = 1'b0;
      push_kind     = EVT_OFF;
      push_key      = pend_key_ff;
      push_last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_tuser == REQ_TIME)) begin
               now_in = $signed(req_tdata[104:73]);
               idx_in = '0;
            end
         end
         ST_OFFER: begin
            // Append the note and announce it
            if (offer_ok && !(event_en_ff && !out_free)) begin
               wr_en                   = 1'b1;
               wr_addr                 = count_ff[IDX_W-1:0];
               wr_data                 = {off_key_ff, end_sat};
               sounding_in[off_key_ff] = 1'b1;
               count_in                = count_ff + 1'b1;
               push                    = event_en_ff;
               push_kind               = EVT_ON;
               push_key                = off_key_ff;
               push_last               = 1'b1;
            end
         end
         ST_EVAL: begin
            if (!expired) begin
               idx_in = idx_ff + 1'b1;
            end else if (!(event_en_ff && pend_valid_ff && !out_free)) begin
               // Swap the last slot in, drop the expired one
               wr_en    = 1'b1;
               wr_data  = rd_last_ff;
               count_in = count_dec;
               sounding_in[rd_cur_ff[SLOT_W-1:TIME_W]] = 1'b0;
               if (event_en_ff) begin
                  push          = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_key_in   = rd_cur_ff[SLOT_W-1:TIME_W];
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register loads on push, clears once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = push_kind;
         rsp_key_in   = push_key;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         sounding_ff   <= '0;
         now_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         track_mask_ff <= 8'hFF;
         event_en_ff   <= 1'b1;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         sounding_ff   <= sounding_in;
         now_ff        <= now_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               REG_TRACK_MASK: track_mask_ff <= csr_wdata;
               REG_EVENT_EN:   event_en_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_key_ff <= pend_key_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
      if (req_take) begin
         off_key_ff   <= req_tdata[6:0];
         off_track_ff <= req_tdata[9:7];
         off_start_ff <= $signed(req_tdata[41:10]);
         off_len_ff   <= req_tdata[72:42];
      end
   end

   // Slot memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_cur_ff  <= slot_mem[idx_ff[IDX_W-1:0]];
      rd_last_ff <= slot_mem[rd_last_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, ((rsp_kind_ff == EVT_ON) ? VEL_ON : VEL_OFF), rsp_key_ff};

   // Checks
   `NDT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(ACTIVE_SLOTS), "slot count above capacity")
   `NDT_ASSERT_NOW(a_eval_in_range, clock, reset, state_ff == ST_EVAL, idx_ff < count_ff, "slot evaluated beyond count")
   `NDT_ASSERT_NOW(a_pend_in_scan, clock, reset, pend_valid_ff, state_ff == ST_READ || state_ff == ST_EVAL || state_ff == ST_FLUSH, "pending event outside a scan")
   `NDT_ASSERT_NEXT(a_offer_grows_one, clock, reset, state_ff == ST_OFFER, count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1, "offer changed count by more than one")

endmodule

`default_nettype wire

// ===== verif/ndt_event_checker.sv =====
// Checker for the note duration tracker: predicts note events and compares them.
`timescale 1ns / 1ps
`default_nettype none

module ndt_event_checker #(
   parameter int SLOTS = ndt_pkg::ACTIVE_SLOTS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire                              csr_addr,
   input  wire  [ndt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   // tdata: note_key, track_id, start_time, note_length, new_time, zero fill
   input  wire  [ndt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: req_type
   input  wire                              req_tuser,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   // tdata: event_key, velocity, zero fill
   input  wire  [ndt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: event_kind
   input  wire                              rsp_tuser,
   input  wire                              rsp_tlast,
   output int                               fail_count,
   output int                               pending_events
);
   import ndt_pkg::*;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
      logic [VEL_W-1:0] vel;
      logic             last;
   } note_event_type;

   // Tracker copy: enables, sounding keys and the slot table
   logic [7:0]               track_enable;
   logic                     events_on;
   logic [KEY_COUNT-1:0]     key_busy;
   logic [KEY_W-1:0]         held_key [0:SLOTS-1];
   logic signed [TIME_W-1:0] held_end [0:SLOTS-1];
   int                       held_count;
   logic signed [TIME_W-1:0] play_time;

   note_event_type event_queue [$];

   initial begin
      fail_count     = 0;
      pending_events = 0;
   end

   function automatic note_event_type make_event(input logic kind,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [VEL_W-1:0] vel);
      note_event_type ev;
      ev.kind = kind;
      ev.key  = key;
      ev.vel  = vel;
      ev.last = 1'b0;
      return ev;
   endfunction

   // Apply one accepted item to the tracker copy and queue the events it causes
   task automatic predict_events(input logic kind, input logic [REQ_DATA_W-1:0] d);
      logic [KEY_W-1:0]         key;
      logic [TRACK_W-1:0]       trk;
      logic signed [TIME_W-1:0] st;
      logic [LEN_W-1:0]         len;
      longint                   fin;
      int                       first;
      int                       i;
      logic [KEY_W-1:0]         gone;
      note_event_type           ev;
      first = event_queue.size();
      if (kind == REQ_NOTE) begin
         key = d[6:0];
         trk = d[9:7];
         st  = d[41:10];
         len = d[72:42];
         fin = longint'(st) + longint'({1'b0, len});
         if (fin > 64'sd2147483647)
            fin = 64'sd2147483647;
         if (track_enable[trk] && !key_busy[key] && st < play_time &&
             longint'(play_time) < fin && held_count < SLOTS) begin
            key_busy[key]        = 1'b1;
            held_key[held_count] = key;
            held_end[held_count] = fin[31:0];
            held_count++;
            if (events_on)
               event_queue.push_back(make_event(EVT_ON, key, VEL_ON));
         end
      end else begin
         play_time = d[104:73];
         i = 0;
         // Scan from slot 0; a swapped-in slot is examined again
         while (i < held_count) begin
            if (held_end[i] < play_time) begin
               gone        = held_key[i];
               held_key[i] = held_key[held_count-1];
               held_end[i] = held_end[held_count-1];
               held_count--;
               key_busy[gone] = 1'b0;
               if (events_on)
                  event_queue.push_back(make_event(EVT_OFF, gone, VEL_OFF));
            end else begin
               i++;
            end
         end
      end
      // Mark the final event of this item
      if (event_queue.size() > first) begin
         ev = event_queue.pop_back();
         ev.last = 1'b1;
         event_queue.push_back(ev);
      end
   endtask

   always @(posedge clock) begin
      note_event_type ev;
      if (reset) begin
         track_enable = 8'hFF;
         events_on    = 1'b1;
         key_busy     = '0;
         held_count   = 0;
         play_time    = '0;
         event_queue.delete();
      end else begin
         // Compare the delivered event first: it belongs to an earlier item
         if (rsp_tvalid && rsp_tready) begin
            if (event_queue.size() == 0) begin
               $error("unexpected event: kind %0d key %0d", rsp_tuser, rsp_tdata[6:0]);
               fail_count++;
            end else begin
               ev = event_queue.pop_front();
               if (rsp_tuser !== ev.kind) begin
                  $error("event_kind mismatch: expected %0d, actual %0d", ev.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[6:0] !== ev.key) begin
                  $error("event_key mismatch: expected %0d, actual %0d",
                         ev.key, rsp_tdata[6:0]);
                  fail_count++;
               end
               if (rsp_tdata[13:7] !== ev.vel) begin
                  $error("velocity mismatch: expected %0d, actual %0d",
                         ev.vel, rsp_tdata[13:7]);
                  fail_count++;
               end
               if (rsp_tlast !== ev.last) begin
                  $error("last_event mismatch: expected %0d, actual %0d", ev.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         // Register writes are the user's to make only while the block is idle; the block does not enforce it
         if (csr_we) begin
            if (csr_addr == REG_TRACK_MASK)
               track_enable = csr_wdata[7:0];
            else if (csr_addr == REG_EVENT_EN)
               events_on = csr_wdata[0];
         end
         if (req_tvalid && req_tready)
            predict_events(req_tuser, req_tdata);
      end
      pending_events = event_queue.size();
   end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Top of the note duration tracker testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import ndt_pkg::*;

   localparam int     SETTLE_CYCLES = 320;
   localparam longint T_MAX         = 64'sd2147483647;
   localparam longint T_MIN         = -64'sd2147483648;
   localparam longint LEN_MAX       = 64'sd2147483647;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic                  csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire                   rsp_tuser;
   wire                   rsp_tlast;
   int                    fail_count;
   int                    pending_events;

   int     tx_idle_pct = 0;
   int     rx_idle_pct = 0;
   int     calm_cycles = 0;
   longint play_pos    = 0;

   note_duration_tracker_core #(.ACTIVE_SLOTS(ACTIVE_SLOTS_DEFAULT)) u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   ndt_event_checker #(.SLOTS(ACTIVE_SLOTS_DEFAULT)) u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending_events(pending_events)
   );

   always #2 clock = ~clock;

   // Stall the result side at random, with occasional calm stretches
   always @(negedge clock) begin
      if (calm_cycles > 0) begin
         calm_cycles--;
         rsp_tready <= 1'b1;
      end else begin
         if ($urandom_range(0, 199) == 0)
            calm_cycles = $urandom_range(20, 60);
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Run-time limit
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [KEY_W-1:0] key,
      input logic [TRACK_W-1:0] trk, input logic [TIME_W-1:0] st,
      input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] nt);
      return {7'd0, nt, len, st, trk, key};
   endfunction

   function automatic logic [TIME_W-1:0] clamp_time(input longint v);
      if (v > T_MAX)
         v = T_MAX;
      if (v < T_MIN)
         v = T_MIN;
      return v[31:0];
   endfunction

   function automatic logic [LEN_W-1:0] clamp_len(input longint v);
      if (v > LEN_MAX)
         v = LEN_MAX;
      if (v < 0)
         v = 0;
      return v[30:0];
   endfunction

   // Present one item, with a random gap first, and hold until accepted
   task automatic send_item(input logic kind, input logic [REQ_DATA_W-1:0] d);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      if (kind == REQ_TIME)
         play_pos = longint'($signed(d[104:73]));
   endtask

   task automatic send_offer(input logic [KEY_W-1:0] key, input logic [TRACK_W-1:0] trk,
                             input longint st, input longint len);
      send_item(REQ_NOTE, pack_req(key, trk, clamp_time(st), clamp_len(len), $urandom));
   endtask

   task automatic send_time(input longint nt);
      send_item(REQ_TIME, pack_req(KEY_W'($urandom), TRACK_W'($urandom), $urandom,
                                   LEN_W'($urandom), clamp_time(nt)));
   endtask

   // Hold off until every expected event has arrived
   task automatic drain_events();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending_events != 0);
   endtask

   // Drain, then let a scan with no events run out
   task automatic settle_block();
      drain_events();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_regs(input logic [7:0] mask, input logic en);
      csr_we    <= 1'b1;
      csr_addr  <= REG_TRACK_MASK;
      csr_wdata <= mask;
      @(negedge clock);
      csr_addr  <= REG_EVENT_EN;
      csr_wdata <= {7'd0, en};
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Fill the slot table past capacity, then expire everything at once
   task automatic fill_table();
      int order [KEY_COUNT];
      int i;
      int j;
      int tmp;
      longint st;
      longint fin;
      for (i = 0; i < KEY_COUNT; i++)
         order[i] = i;
      for (i = 0; i < KEY_COUNT; i++) begin
         j        = $urandom_range(0, KEY_COUNT - 1);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      send_time(longint'($urandom_range(0, 50000)));
      for (i = 0; i < 72; i++) begin
         st  = play_pos - 1 - $urandom_range(0, 100);
         fin = play_pos + 100000 + $urandom_range(0, 1000);
         send_offer(KEY_W'(order[i]), TRACK_W'($urandom_range(0, 7)), st, fin - st);
      end
      send_time(play_pos + 200000);
   endtask

   // Mostly well-formed offers around the current time, plus noise and broken items
   task automatic run_random(input int count);
      int     r;
      longint st;
      longint fin;
      logic   kind;
      repeat (count) begin
         if ($urandom_range(0, 29) == 0)
            drain_events();
         r = $urandom_range(0, 99);
         if (r < 10) begin
            kind = 1'($urandom_range(0, 1));
            send_item(kind, pack_req(KEY_W'($urandom), TRACK_W'($urandom), $urandom,
                                     LEN_W'($urandom), $urandom));
         end else if (r < 60) begin
            st  = play_pos - $urandom_range(1, 4000);
            fin = play_pos + $urandom_range(1, 6000);
            send_offer(KEY_W'($urandom_range(0, 127)), TRACK_W'($urandom_range(0, 7)), st,
                       fin - longint'($signed(clamp_time(st))));
         end else if (r < 70) begin
            if ($urandom_range(0, 1)) begin
               st = play_pos + $urandom_range(0, 100);
               send_offer(KEY_W'($urandom_range(0, 127)), TRACK_W'($urandom_range(0, 7)), st,
                          longint'($urandom_range(0, 5000)));
            end else begin
               st = play_pos - $urandom_range(1, 3000);
               send_offer(KEY_W'($urandom_range(0, 127)), TRACK_W'($urandom_range(0, 7)), st,
                          play_pos - st - $urandom_range(0, 2));
            end
         end else begin
            // Pull a far-away time back near zero to keep ends clear of saturation
            if (play_pos > 64'sd1073741824 || play_pos < -64'sd1073741824)
               send_time(longint'($urandom_range(0, 100000)));
            else if ($urandom_range(0, 4) == 0)
               send_time(play_pos - $urandom_range(0, 500));
            else
               send_time(play_pos + $urandom_range(0, 2500));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = REG_TRACK_MASK;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_NOTE;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: window edges, key and track extremes, saturation, swap rescan
      set_regs(8'hFF, 1'b1);
      send_offer(0, 0, -1, 2);
      send_offer(127, 7, T_MIN, LEN_MAX);
      send_offer(127, 7, -1, LEN_MAX);
      send_offer(0, 3, -5, 100);
      send_offer(5, 1, 0, 50);
      send_offer(6, 2, -10, 0);
      send_time(2147483000);
      send_offer(10, 4, T_MAX, LEN_MAX);
      send_offer(10, 5, 2147482000, LEN_MAX);
      send_offer(11, 6, 2147482500, 500);
      send_time(T_MAX);
      send_time(T_MIN);
      send_offer(12, 0, T_MIN, 0);
      send_time(0);
      settle_block();
      set_regs(8'h00, 1'b1);
      send_offer(20, 0, -100, 1000);
      settle_block();
      set_regs(8'h80, 1'b0);
      send_offer(21, 7, -100, 1000);
      send_offer(22, 6, -100, 1000);
      send_time(2000);
      settle_block();
      set_regs(8'hFF, 1'b1);
      send_offer(30, 1, 1990, 20);
      send_offer(31, 2, 1999, 1001);
      send_offer(32, 3, 1500, 520);
      send_time(2050);
      settle_block();

      // Random: sender rarely idle, receiver often stalled
      tx_idle_pct = 7;
      rx_idle_pct = 66;
      fill_table();
      run_random(50);
      send_time(T_MAX - 1);
      settle_block();

      // Random: sender often idle, receiver rarely stalled
      tx_idle_pct = 66;
      rx_idle_pct = 7;
      set_regs(8'($urandom_range(1, 254)), 1'b1);
      send_time(0);
      run_random(30);
      settle_block();
      set_regs(8'hFF, 1'b0);
      run_random(20);
      send_time(T_MAX - 1);
      settle_block();

      // Random: no idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_regs(8'hFF, 1'b1);
      send_time(0);
      run_random(50);

      // Wait for the tail, then give the verdict
      settle_block();
      if (fail_count == 0 && pending_events == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/ndt_pkg.sv
src/note_duration_tracker_core.sv
verif/ndt_event_checker.sv
verif/testbench.sv
